>>> sv/wstd_pkg.sv
// Package: shared constants, types and controller/datapath command and status structs.
package wstd_pkg;
    localparam int MAX_SERVERS = 256;
    localparam int WEIGHT_BITS = 20;
    localparam int IDX_BITS    = $clog2(MAX_SERVERS);
    localparam int CNT_BITS    = IDX_BITS + 1;
    localparam int KEY_BITS    = WEIGHT_BITS + IDX_BITS;
    localparam int TIME_BITS   = 48;
    localparam int DUR_BITS    = 20;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef logic [KEY_BITS-1:0]  key_t;
    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [IDX_BITS-1:0]  idx_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,       // append key to free heap, begin sift up
        OP_PREP,       // capture duration, raise time to task count
        OP_CHECK,      // read busy top for release test
        OP_BPOP,       // start busy pop: latch top key, move last to root
        OP_FPUSH,      // push popped busy key into free heap
        OP_JUMP,       // time := busy top finish
        OP_FPOP,       // start free pop
        OP_BPUSH,      // push chosen key into busy heap
        OP_FINISH      // advance task index, form the no-server result
    } op_t;

    typedef struct packed {
        op_t  op;
        logic step;    // advance running sift by one state
    } cmd_t;

    typedef struct packed {
        logic sift_busy;
        logic rel_ok;      // busy nonempty and top finish <= time
        logic free_empty;
        logic busy_empty;
        logic no_servers;
        logic load_ok;
    } sts_t;
endpackage

>>> sv/wstd_datapath.sv
// Datapath: heap memories, sift engine, counters and time registers.
module wstd_datapath
    import wstd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cmd_t                   cmd,
    input  logic [WEIGHT_BITS-1:0] in_weight,
    input  logic [DUR_BITS-1:0]    in_duration,
    output sts_t                   sts,
    output logic [7:0]             res_index,
    output time_t                  res_time,
    output logic                   res_none
);
    // Heap sift engine, per level a read, then a compare and move; sift down ends with one
    // write of the sifted entry.
    typedef enum logic [2:0] {S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP, S_DN_WR} sift_t;

    key_t  free_mem [MAX_SERVERS];
    time_t bfin_mem [MAX_SERVERS];
    key_t  bkey_mem [MAX_SERVERS];

    cnt_t  free_cnt_reg, busy_cnt_reg, srv_cnt_reg;
    time_t cur_time_reg, task_idx_reg;
    sift_t sift_reg;
    logic  sel_busy_reg;               // which heap the sift is working on
    idx_t  pos_reg;
    key_t  nk_reg;                     // key being sifted
    time_t nf_reg;                     // finish being sifted
    key_t  top_key_reg;
    time_t top_fin_reg;
    logic  top_vld_reg;
    key_t  ok_reg, lk_reg, rk_reg;
    time_t lf_reg, rf_reg;
    logic  lv_reg, rv_reg;
    key_t  pop_key_reg;
    logic [DUR_BITS-1:0] dur_reg;

    // Busy root is copied into top_* by OP_CHECK.
    idx_t  parent, lchild, rchild;
    cnt_t  lc_full, rc_full, cnt_cur;
    assign parent  = idx_t'((pos_reg - 1'b1) >> 1);
    assign lc_full = cnt_t'({pos_reg, 1'b1});
    assign rc_full = lc_full + 1'b1;
    assign lchild  = lc_full[IDX_BITS-1:0];
    assign rchild  = rc_full[IDX_BITS-1:0];
    assign cnt_cur = sel_busy_reg ? busy_cnt_reg : free_cnt_reg;

    function automatic logic lt(input logic b, input time_t fa, input key_t ka,
                                input time_t fb, input key_t kb);
        lt = b ? ((fa != fb) ? (fa < fb) : (ka < kb)) : (ka < kb);
    endfunction

    logic  smaller_l, smaller_r, pick_r;
    assign smaller_l = lv_reg && lt(sel_busy_reg, lf_reg, lk_reg, nf_reg, nk_reg);
    assign smaller_r = rv_reg && lt(sel_busy_reg, rf_reg, rk_reg, nf_reg, nk_reg);
    assign pick_r    = smaller_r && (!smaller_l ||
                       lt(sel_busy_reg, rf_reg, rk_reg, lf_reg, lk_reg));

    time_t fin_sum;
    logic [TIME_BITS:0] fin_wide;
    assign fin_wide = {1'b0, cur_time_reg} + (TIME_BITS+1)'(dur_reg);
    assign fin_sum  = fin_wide[TIME_BITS] ? TIME_MAX : fin_wide[TIME_BITS-1:0];

    cnt_t  last_f, last_b;
    assign last_f = free_cnt_reg - 1'b1;
    assign last_b = busy_cnt_reg - 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_cnt_reg <= '0;
            busy_cnt_reg <= '0;
            srv_cnt_reg  <= '0;
            cur_time_reg <= '0;
            task_idx_reg <= '0;
            sift_reg     <= S_IDLE;
            top_vld_reg  <= 1'b0;
            res_none     <= 1'b0;
        end else begin
            unique case (cmd.op)
                OP_LOAD: begin
                    free_mem[free_cnt_reg[IDX_BITS-1:0]] <= {in_weight, srv_cnt_reg[IDX_BITS-1:0]};
                    nk_reg       <= {in_weight, srv_cnt_reg[IDX_BITS-1:0]};
                    pos_reg      <= free_cnt_reg[IDX_BITS-1:0];
                    sel_busy_reg <= 1'b0;
                    free_cnt_reg <= free_cnt_reg + 1'b1;
                    srv_cnt_reg  <= srv_cnt_reg + 1'b1;
                    sift_reg     <= S_UP_RD;
                end
                OP_PREP: begin
                    dur_reg <= in_duration;
                    if (cur_time_reg < task_idx_reg) cur_time_reg <= task_idx_reg;
                end
                OP_CHECK: begin
                    top_fin_reg <= bfin_mem[0];
                    top_key_reg <= bkey_mem[0];
                    top_vld_reg <= busy_cnt_reg != '0;
                end
                OP_BPOP: begin
                    pop_key_reg  <= top_key_reg;
                    nf_reg       <= bfin_mem[last_b[IDX_BITS-1:0]];
                    nk_reg       <= bkey_mem[last_b[IDX_BITS-1:0]];
                    busy_cnt_reg <= last_b;
                    pos_reg      <= '0;
                    sel_busy_reg <= 1'b1;
                    sift_reg     <= S_DN_RD;
                end
                OP_FPUSH: begin
                    free_mem[free_cnt_reg[IDX_BITS-1:0]] <= pop_key_reg;
                    nk_reg       <= pop_key_reg;
                    pos_reg      <= free_cnt_reg[IDX_BITS-1:0];
                    sel_busy_reg <= 1'b0;
                    free_cnt_reg <= free_cnt_reg + 1'b1;
                    sift_reg     <= S_UP_RD;
                end
                OP_JUMP: cur_time_reg <= top_fin_reg;
                OP_FPOP: begin
                    pop_key_reg  <= free_mem[0];
                    nk_reg       <= free_mem[last_f[IDX_BITS-1:0]];
                    free_cnt_reg <= last_f;
                    pos_reg      <= '0;
                    sel_busy_reg <= 1'b0;
                    sift_reg     <= S_DN_RD;
                end
                OP_BPUSH: begin
                    bfin_mem[busy_cnt_reg[IDX_BITS-1:0]] <= fin_sum;
                    bkey_mem[busy_cnt_reg[IDX_BITS-1:0]] <= pop_key_reg;
                    nf_reg       <= fin_sum;
                    nk_reg       <= pop_key_reg;
                    pos_reg      <= busy_cnt_reg[IDX_BITS-1:0];
                    sel_busy_reg <= 1'b1;
                    busy_cnt_reg <= busy_cnt_reg + 1'b1;
                    sift_reg     <= S_UP_RD;
                    res_index    <= pop_key_reg[7:0];
                    res_time     <= cur_time_reg;
                    res_none     <= 1'b0;
                end
                OP_FINISH: begin
                    if (srv_cnt_reg == '0) begin
                        res_index <= '0;
                        res_time  <= '0;
                        res_none  <= 1'b1;
                    end
                    if (task_idx_reg != TIME_MAX) task_idx_reg <= task_idx_reg + 1'b1;
                end
                default: ;
            endcase

            if (cmd.step) begin
                unique case (sift_reg)
                    S_UP_RD: begin
                        if (pos_reg == '0) sift_reg <= S_IDLE;
                        else begin
                            ok_reg   <= sel_busy_reg ? bkey_mem[parent] : free_mem[parent];
                            lf_reg   <= bfin_mem[parent];
                            sift_reg <= S_UP_CMP;
                        end
                    end
                    S_UP_CMP: begin
                        if (lt(sel_busy_reg, nf_reg, nk_reg, lf_reg, ok_reg)) begin
                            if (sel_busy_reg) begin
                                bfin_mem[pos_reg] <= lf_reg;
                                bkey_mem[pos_reg] <= ok_reg;
                                bfin_mem[parent]  <= nf_reg;
                                bkey_mem[parent]  <= nk_reg;
                            end else begin
                                free_mem[pos_reg] <= ok_reg;
                                free_mem[parent]  <= nk_reg;
                            end
                            pos_reg  <= parent;
                            sift_reg <= S_UP_RD;
                        end else sift_reg <= S_IDLE;
                    end
                    S_DN_RD: begin
                        lv_reg <= lc_full < cnt_cur;
                        rv_reg <= rc_full < cnt_cur;
                        lk_reg <= sel_busy_reg ? bkey_mem[lchild] : free_mem[lchild];
                        rk_reg <= sel_busy_reg ? bkey_mem[rchild] : free_mem[rchild];
                        lf_reg <= bfin_mem[lchild];
                        rf_reg <= bfin_mem[rchild];
                        sift_reg <= S_DN_CMP;
                    end
                    S_DN_CMP: begin
                        if (smaller_l || smaller_r) begin
                            if (sel_busy_reg) begin
                                bfin_mem[pos_reg] <= pick_r ? rf_reg : lf_reg;
                                bkey_mem[pos_reg] <= pick_r ? rk_reg : lk_reg;
                            end else free_mem[pos_reg] <= pick_r ? rk_reg : lk_reg;
                            pos_reg  <= pick_r ? rchild : lchild;
                            sift_reg <= S_DN_RD;
                        end else sift_reg <= S_DN_WR;
                    end
                    S_DN_WR: begin
                        if (sel_busy_reg) begin
                            bfin_mem[pos_reg] <= nf_reg;
                            bkey_mem[pos_reg] <= nk_reg;
                        end else free_mem[pos_reg] <= nk_reg;
                        sift_reg <= S_IDLE;
                    end
                    default: sift_reg <= S_IDLE;
                endcase
            end
        end
    end

    assign sts.sift_busy  = sift_reg != S_IDLE;
    assign sts.rel_ok     = top_vld_reg && (top_fin_reg <= cur_time_reg);
    assign sts.free_empty = free_cnt_reg == '0;
    assign sts.busy_empty = busy_cnt_reg == '0;
    assign sts.no_servers = srv_cnt_reg == '0;
    assign sts.load_ok    = (task_idx_reg == '0) && (srv_cnt_reg != cnt_t'(MAX_SERVERS));
endmodule

>>> sv/wstd_ctrl.sv
// Controller: sequences load and task operations on the datapath.
module wstd_ctrl
    import wstd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  logic in_mode,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    typedef enum logic [3:0] {
        C_IDLE, C_WAIT_LOAD, C_CHECK, C_TEST, C_WAIT_REL, C_FPUSH_WAIT,
        C_JUMP, C_FPOP, C_FPOP_WAIT, C_BPUSH_WAIT, C_FINISH, C_OUT
    } st_t;

    st_t  st_reg, st_next;
    logic jumped_reg, jumped_next;
    logic pushed_reg, pushed_next;

    assign in_ready  = st_reg == C_IDLE;
    assign out_valid = st_reg == C_OUT;

    always_comb begin
        st_next     = st_reg;
        jumped_next = jumped_reg;
        pushed_next = pushed_reg;
        cmd.op      = OP_NONE;
        cmd.step    = sts.sift_busy;
        unique case (st_reg)
            C_IDLE: begin
                if (in_valid) begin
                    if (!in_mode) begin
                        if (sts.load_ok) begin
                            cmd.op  = OP_LOAD;
                            st_next = C_WAIT_LOAD;
                        end
                    end else if (sts.no_servers) begin
                        cmd.op  = OP_FINISH;
                        st_next = C_OUT;
                    end else begin
                        cmd.op      = OP_PREP;
                        jumped_next = 1'b0;
                        st_next     = C_CHECK;
                    end
                end
            end
            C_WAIT_LOAD: if (!sts.sift_busy) st_next = C_IDLE;
            C_CHECK: begin
                if (!sts.sift_busy) begin
                    cmd.op  = OP_CHECK;
                    st_next = C_TEST;
                end
            end
            C_TEST: begin
                if (sts.rel_ok) begin
                    cmd.op      = OP_BPOP;
                    pushed_next = 1'b0;
                    st_next     = C_WAIT_REL;
                end else if (sts.free_empty && !sts.busy_empty && !jumped_reg) begin
                    st_next = C_JUMP;
                end else st_next = C_FPOP;
            end
            C_WAIT_REL: if (!sts.sift_busy) st_next = C_FPUSH_WAIT;
            C_FPUSH_WAIT: begin
                if (!pushed_reg) begin
                    cmd.op      = OP_FPUSH;
                    pushed_next = 1'b1;
                end else if (!sts.sift_busy) st_next = C_CHECK;
            end
            C_JUMP: begin
                cmd.op      = OP_JUMP;
                jumped_next = 1'b1;
                st_next     = C_CHECK;
            end
            C_FPOP: begin
                cmd.op  = OP_FPOP;
                st_next = C_FPOP_WAIT;
            end
            C_FPOP_WAIT: begin
                if (!sts.sift_busy) begin
                    cmd.op  = OP_BPUSH;
                    st_next = C_BPUSH_WAIT;
                end
            end
            C_BPUSH_WAIT: if (!sts.sift_busy) st_next = C_FINISH;
            C_FINISH: begin
                cmd.op  = OP_FINISH;
                st_next = C_OUT;
            end
            C_OUT: if (out_ready) st_next = C_IDLE;
            default: st_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= C_IDLE;
            jumped_reg <= 1'b0;
            pushed_reg <= 1'b0;
        end else begin
            st_reg     <= st_next;
            jumped_reg <= jumped_next;
            pushed_reg <= pushed_next;
        end
    end
endmodule

>>> sv/weighted_server_task_dispatcher_core.sv
// Top level: weighted server task dispatcher.
// One item at a time. Each heap sift reads and then compares and moves per level, on heaps of up
// to 256 servers. A load is ready for the next item after its free-heap sift-up. A task runs
// one free-heap sift-down and one busy-heap sift-up; each released server adds a busy-heap
// sift-down and a free-heap sift-up, and with no server free, time jumps to the earliest busy
// finish. A task with no servers loaded gives the no-server result without any heap work.
// The result is held until taken; the next item is accepted after the transfer.
module weighted_server_task_dispatcher_core
    import wstd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // [19:0] weight, [39:20] duration
    input  logic        s_tuser,  // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // [7:0] server_index, [55:8] start_time
    output logic        m_tuser   // no_server
);
    cmd_t       cmd;
    sts_t       sts;
    logic [7:0] res_index;
    time_t      res_time;

    wstd_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid (s_tvalid), .in_ready (s_tready), .in_mode (s_tuser),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .sts, .cmd
    );

    wstd_datapath u_dp (
        .aclk, .aresetn, .cmd,
        .in_weight  (s_tdata[WEIGHT_BITS-1:0]),
        .in_duration(s_tdata[39:20]),
        .sts, .res_index, .res_time, .res_none(m_tuser)
    );

    assign m_tdata = {res_time, res_index};
endmodule

>>> sv/wstd_checker.sv
// Checker: port-level assertions for the dispatcher, bound to the top level.
module wstd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tuser
);
    a_one_at_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0) else $error("no_server result nonzero");
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("valid after reset");
endmodule

bind weighted_server_task_dispatcher_core wstd_checker u_chk (
    .aclk, .aresetn, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);

>>> verif/tb.sv
// Testbench for the weighted server task dispatcher: server loads, task dispatch and back-pressure.
module tb;
    import wstd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TASK = 1'b1;
    localparam logic [63:0] T48 = 64'hFFFF_FFFF_FFFF;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;  // [19:0] weight, [39:20] duration
    logic        s_tuser = 1'b0;  // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;  // [7:0] server_index, [55:8] start_time
    logic        m_tuser;  // no_server

    weighted_server_task_dispatcher_core dut (.*);

    typedef struct {
        logic [7:0]  server_index;
        logic [47:0] start_time;
        logic        no_server;
    } dispatch_t;

    dispatch_t   dispatch_q[$];
    logic [63:0] fheap[MAX_SERVERS];
    logic [63:0] bfin[MAX_SERVERS];
    logic [63:0] bkey[MAX_SERVERS];
    int          nfree, nbusy, nserv;
    logic [63:0] now_t, ntask;
    int          errors, dispatched, loads_sent, tasks_sent;
    bit          idle_on = 1'b1;
    int          long_hold = 0;

    initial forever #5 aclk = ~aclk;
    initial begin
        #30ms;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    endtask

    function automatic void fpush(input logic [63:0] k);
        int i, p;
        logic [63:0] t;
        if (nfree >= MAX_SERVERS) return;
        i = nfree++;
        fheap[i] = k;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (fheap[p] > fheap[i]) begin
                t = fheap[p]; fheap[p] = fheap[i]; fheap[i] = t; i = p;
            end else break;
        end
    endfunction

    function automatic logic [63:0] fpop();
        logic [63:0] top, t;
        int i, l, r, s;
        if (nfree == 0) return 0;
        top = fheap[0];
        nfree--;
        fheap[0] = fheap[nfree];
        i = 0;
        forever begin
            l = 2 * i + 1; r = 2 * i + 2; s = i;
            if (l < nfree && fheap[l] < fheap[s]) s = l;
            if (r < nfree && fheap[r] < fheap[s]) s = r;
            if (s == i) break;
            t = fheap[i]; fheap[i] = fheap[s]; fheap[s] = t;
            i = s;
        end
        return top;
    endfunction

    function automatic bit bless(input int x, input int y);
        if (bfin[x] != bfin[y]) return bfin[x] < bfin[y];
        return bkey[x] < bkey[y];
    endfunction

    function automatic void bswap(input int x, input int y);
        logic [63:0] t;
        t = bfin[x]; bfin[x] = bfin[y]; bfin[y] = t;
        t = bkey[x]; bkey[x] = bkey[y]; bkey[y] = t;
    endfunction

    function automatic void bpush(input logic [63:0] f, input logic [63:0] k);
        int i, p;
        if (nbusy >= MAX_SERVERS) return;
        i = nbusy++;
        bfin[i] = f;
        bkey[i] = k;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (bless(i, p)) begin
                bswap(i, p); i = p;
            end else break;
        end
    endfunction

    function automatic logic [63:0] bpop();
        logic [63:0] k;
        int i, l, r, s;
        if (nbusy == 0) return 0;
        k = bkey[0];
        nbusy--;
        bfin[0] = bfin[nbusy];
        bkey[0] = bkey[nbusy];
        i = 0;
        forever begin
            l = 2 * i + 1; r = 2 * i + 2; s = i;
            if (l < nbusy && bless(l, s)) s = l;
            if (r < nbusy && bless(r, s)) s = r;
            if (s == i) break;
            bswap(i, s);
            i = s;
        end
        return k;
    endfunction

    function automatic void release_done();
        while (nbusy > 0 && bfin[0] <= now_t) fpush(bpop());
    endfunction

    function automatic void predict_dispatch(input logic mode, input logic [39:0] d);
        dispatch_t   r;
        logic [63:0] k, fin;
        if (mode == MODE_LOAD) begin
            if (ntask == 0 && nserv < MAX_SERVERS) begin
                fpush((64'(d[19:0]) << 32) | 64'(nserv));
                nserv++;
            end
            return;
        end
        if (nserv == 0) begin
            r.server_index = '0; r.start_time = '0; r.no_server = 1'b1;
        end else begin
            if (now_t < ntask) now_t = ntask;
            release_done();
            if (nfree == 0 && nbusy > 0) begin
                now_t = bfin[0];
                release_done();
            end
            k = fpop();
            fin = now_t + 64'(d[39:20]);
            if (fin > T48) fin = T48;
            bpush(fin, k);
            r.server_index = k[7:0]; r.start_time = now_t[47:0]; r.no_server = 1'b0;
        end
        if (ntask < T48) ntask++;
        dispatch_q.push_back(r);
    endfunction

    task automatic send_item(input logic mode, input logic [19:0] w, input logic [19:0] d);
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {d, w};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_dispatch(mode, {d, w});
        if (mode == MODE_LOAD) loads_sent++; else tasks_sent++;
    endtask

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (long_hold > 0) begin
                long_hold--;
                m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        dispatch_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (dispatch_q.size() == 0) begin
                report("unexpected transfer", m_tdata, 0);
            end else begin
                w = dispatch_q.pop_front();
                dispatched++;
                if (m_tdata[7:0] !== w.server_index) report("server_index", m_tdata[7:0], w.server_index);
                if (m_tdata[55:8] !== w.start_time) report("start_time", m_tdata[55:8], w.start_time);
                if (m_tuser !== w.no_server) report("no_server", m_tuser, w.no_server);
            end
        end
    end

    task automatic test_load_servers();
        send_item(MODE_LOAD, 20'h00000, 20'hFFFFF);
        send_item(MODE_LOAD, 20'hFFFFF, 20'h00000);
        send_item(MODE_LOAD, 20'h00000, 20'h12345);
        send_item(MODE_LOAD, 20'hAAAAA, 20'h55555);
        send_item(MODE_LOAD, 20'h55555, 20'hAAAAA);
        // fill past capacity, the extra loads are dropped
        for (int i = 5; i < MAX_SERVERS + 4; i++)
            send_item(MODE_LOAD, (i % 5 == 0) ? 20'($urandom) : 20'($urandom_range(0, 15)),
                      20'($urandom));
    endtask

    task automatic test_dispatch_directed();
        send_item(MODE_TASK, 20'hFFFFF, 20'h00000);
        send_item(MODE_TASK, 20'h00000, 20'hFFFFF);
        send_item(MODE_TASK, 20'h12345, 20'h00001);
        send_item(MODE_LOAD, 20'h00000, 20'h00000);  // ignored after first task
        for (int i = 0; i < 12; i++) send_item(MODE_TASK, 20'($urandom), 20'($urandom_range(0, 3)));
    endtask

    task automatic test_backpressure();
        long_hold = 300;
        for (int i = 0; i < 10; i++) send_item(MODE_TASK, 20'($urandom), 20'($urandom_range(0, 400)));
    endtask

    task automatic test_random_dispatch(input int n);
        logic [19:0] d;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0:       d = 20'($urandom);
                1, 2:    d = 20'($urandom_range(0, 2));
                default: d = 20'($urandom_range(0, 600));
            endcase
            send_item(($urandom_range(0, 19) == 0) ? MODE_LOAD : MODE_TASK, 20'($urandom), d);
        end
    endtask

    task automatic test_drain();
        int n;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        n = 0;
        while (dispatch_q.size() != 0 && n < 200000) begin
            @(posedge aclk);
            n++;
        end
        repeat (200) @(posedge aclk);
    endtask

    initial begin
        errors = 0; dispatched = 0; loads_sent = 0; tasks_sent = 0;
        nfree = 0; nbusy = 0; nserv = 0; now_t = 0; ntask = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_load_servers();
        test_dispatch_directed();
        test_backpressure();
        test_random_dispatch(1500);
        idle_on = 1'b0;
        test_random_dispatch(300);
        test_drain();
        $display("Covered %0d loads (%0d servers kept) and %0d tasks, %0d results checked,",
                 loads_sent, nserv, tasks_sent, dispatched);
        $display("with capacity overflow, late loads, ties, long stalls and output back-pressure.");
        if (errors == 0 && dispatch_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
